// File: sv/aldq_pkg.sv
// ----------------------------------------------------------------------------
// aldq_pkg
// Shared types and constants for the active list ring deque: operation codes,
// field widths and the packed layout of one list entry.
// ----------------------------------------------------------------------------
package aldq_pkg;

	// Default number of entries in the list
	localparam int DEPTH_DEF = 32;

	// Field widths
	localparam int MODE_W  = 3;
	localparam int INDEX_W = 5;
	localparam int LDEST_W = 5;
	localparam int ODEST_W = 6;
	localparam int PC_W    = 64;
	localparam int COUNT_W = 6;

	// Operation codes
	typedef enum logic [MODE_W-1:0] {
		OP_PUSH      = 3'd0,
		OP_POP_FRONT = 3'd1,
		OP_POP_BACK  = 3'd2,
		OP_RD_FRONT  = 3'd3,
		OP_RD_BACK   = 3'd4,
		OP_RD_AT     = 3'd5,
		OP_WR_AT     = 3'd6,
		OP_FLUSH     = 3'd7
	} mode_t;

	// One stored entry
	typedef struct packed {
		logic               done;
		logic               exception;
		logic [LDEST_W-1:0] logical_dest;
		logic [ODEST_W-1:0] old_dest;
		logic [PC_W-1:0]    pc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/aldq_ram.sv
// ----------------------------------------------------------------------------
// aldq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module aldq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/active_list_ring_deque.sv
// ----------------------------------------------------------------------------
// active_list_ring_deque
// Active list (reorder buffer) kept as a circular deque of DEPTH entries.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one operation per transfer:
//   push, pop front, pop back, read front, read back, read at an offset from
//   the head, write at an offset from the head, or flush. Each transfer gives
//   exactly one result on the output channel (out_valid / out_stall) with the
//   status, the entry read (zero unless a read succeeded) and the occupancy,
//   empty, full and free-slot counts after the operation.
//   The accepting edge registers the entry memory read and the status in the
//   read stage; the result then moves into the output register, which raises
//   out_valid, as soon as that register is empty or its result is taken.
//   Throughput is one operation per cycle while the output is not stalled.
//   When the receiver stalls, the result holds in the output register, one
//   more result waits in the read stage, and then in_stall rises.
//   Reset clears the pointers, the count and the valid flags; entry contents
//   are undefined until written. Flush returns the pointers and the count to
//   zero and keeps the entry contents.
// ----------------------------------------------------------------------------
module active_list_ring_deque #(
	parameter int DEPTH = aldq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Operation channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [aldq_pkg::MODE_W-1:0]   mode,
	input  logic [aldq_pkg::INDEX_W-1:0]  slot_offset,
	input  logic                          entry_done,
	input  logic                          entry_exception,
	input  logic [aldq_pkg::LDEST_W-1:0]  entry_logical_dest,
	input  logic [aldq_pkg::ODEST_W-1:0]  entry_old_dest,
	input  logic [aldq_pkg::PC_W-1:0]     entry_pc,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ok,
	output logic                          out_done,
	output logic                          out_exception,
	output logic [aldq_pkg::LDEST_W-1:0]  out_logical_dest,
	output logic [aldq_pkg::ODEST_W-1:0]  out_old_dest,
	output logic [aldq_pkg::PC_W-1:0]     out_pc,
	output logic [aldq_pkg::COUNT_W-1:0]  occupancy,
	output logic                          is_empty,
	output logic                          is_full,
	output logic [aldq_pkg::COUNT_W-1:0]  free_slots
);

	import aldq_pkg::*;

	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int NOFF  = 1 << INDEX_W;

	// Status carried from the memory access stage to the output register
	typedef struct packed {
		logic          ok;
		logic          rd;
		logic [CW-1:0] count;
	} stage_t;

	logic          accept;
	logic          s1_adv;
	logic          out_xfer;

	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;

	logic [PW-1:0] head_inc, tail_inc, tail_dec;
	logic [PW-1:0] off_mod [NOFF];
	logic [PW:0]   idx_sum;
	logic [PW-1:0] idx_slot;

	logic          ram_we, ram_re;
	logic [PW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	logic          s1_valid_q;
	stage_t        s1_d, s1_s1;
	logic          is_empty_now, is_full_now;

	// Handshakes
	assign out_xfer = out_valid & ~out_stall;
	assign s1_adv   = s1_valid_q & (~out_valid | ~out_stall);
	assign in_stall = s1_valid_q & out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Pointer neighbors with wrap at DEPTH
	assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? PW'(DEPTH - 1) : tail_q - 1'b1;

	// Reduce the offset modulo DEPTH through a constant table
	for (genvar i = 0; i < NOFF; i++) begin : g_off
		assign off_mod[i] = PW'(i % DEPTH);
	end

	// Indexed slot: one add and one conditional subtract
	assign idx_sum  = {1'b0, head_q} + {1'b0, off_mod[slot_offset]};
	assign idx_slot = (idx_sum >= (PW+1)'(DEPTH)) ? PW'(idx_sum - (PW+1)'(DEPTH))
	                                              : idx_sum[PW-1:0];

	assign is_empty_now = (count_q == '0);
	assign is_full_now  = (count_q == CW'(DEPTH));

	// Entry to store
	always_comb begin
		ram_wdata.done         = entry_done;
		ram_wdata.exception    = entry_exception;
		ram_wdata.logical_dest = entry_logical_dest;
		ram_wdata.old_dest     = entry_old_dest;
		ram_wdata.pc           = entry_pc;
	end

	// Decode the operation: pointer updates and memory access
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = tail_q;
		ram_raddr = head_q;
		s1_d.ok   = 1'b1;
		s1_d.rd   = 1'b0;
		case (mode_t'(mode))
			OP_PUSH: begin
				if (is_full_now) begin
					s1_d.ok = 1'b0;
				end else begin
					ram_we  = 1'b1;
					tail_d  = tail_inc;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty_now) begin
					s1_d.ok = 1'b0;
				end else begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty_now) begin
					s1_d.ok = 1'b0;
				end else begin
					tail_d  = tail_dec;
					count_d = count_q - 1'b1;
				end
			end
			OP_RD_FRONT: begin
				if (is_empty_now) begin
					s1_d.ok = 1'b0;
				end else begin
					ram_re  = 1'b1;
					s1_d.rd = 1'b1;
				end
			end
			OP_RD_BACK: begin
				ram_raddr = tail_dec;
				if (is_empty_now) begin
					s1_d.ok = 1'b0;
				end else begin
					ram_re  = 1'b1;
					s1_d.rd = 1'b1;
				end
			end
			OP_RD_AT: begin
				ram_raddr = idx_slot;
				ram_re    = 1'b1;
				s1_d.rd   = 1'b1;
			end
			OP_WR_AT: begin
				ram_waddr = idx_slot;
				ram_we    = 1'b1;
			end
			OP_FLUSH: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
				s1_d.ok = 1'b0;
			end
		endcase
		s1_d.count = count_d;
	end

	// Entry memory
	aldq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we & accept),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re & accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Advance the pointers and the count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Memory access stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Memory access stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (out_xfer) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload: entry fields only for a successful read
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ok         <= s1_s1.ok;
			occupancy  <= COUNT_W'(s1_s1.count);
			is_empty   <= (s1_s1.count == '0);
			is_full    <= (s1_s1.count == CW'(DEPTH));
			free_slots <= COUNT_W'(CW'(DEPTH) - s1_s1.count);
			if (s1_s1.rd) begin
				out_done         <= ram_rdata.done;
				out_exception    <= ram_rdata.exception;
				out_logical_dest <= ram_rdata.logical_dest;
				out_old_dest     <= ram_rdata.old_dest;
				out_pc           <= ram_rdata.pc;
			end else begin
				out_done         <= 1'b0;
				out_exception    <= 1'b0;
				out_logical_dest <= '0;
				out_old_dest     <= '0;
				out_pc           <= '0;
			end
		end
	end

endmodule

// File: sim/tb_active_list_ring_deque.sv
// ----------------------------------------------------------------------------
// tb_active_list_ring_deque
// Self-checking bench for the active list ring deque. A queue of planned
// operations (directed corner cases, then random phases of fills, drains,
// mixed and indexed traffic) feeds a driver; every accepted transfer runs
// through a bit-accurate deque predictor, and a monitor checks each result
// field by field against the oldest prediction. Both channels idle at random,
// and the receiver holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module tb_active_list_ring_deque;
	import aldq_pkg::*;

	localparam int ROB_DEPTH   = DEPTH_DEF;
	localparam int RAND_OPS    = 1350;
	localparam int HOLD_CYCLES = 80;

	// One planned operation
	typedef struct packed {
		mode_t              mode;
		logic [INDEX_W-1:0] idx;
		entry_t             ent;
	} rob_op_t;

	// One predicted result
	typedef struct packed {
		logic               ok;
		entry_t             ent;
		logic [COUNT_W-1:0] occ;
		logic               empty;
		logic               full;
		logic [COUNT_W-1:0] free;
	} rob_status_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               in_valid;
	logic               in_stall;
	logic [MODE_W-1:0]  mode;
	logic [INDEX_W-1:0] slot_offset;
	logic               entry_done;
	logic               entry_exception;
	logic [LDEST_W-1:0] entry_logical_dest;
	logic [ODEST_W-1:0] entry_old_dest;
	logic [PC_W-1:0]    entry_pc;

	logic               out_valid;
	logic               out_stall;
	logic               ok;
	logic               out_done;
	logic               out_exception;
	logic [LDEST_W-1:0] out_logical_dest;
	logic [ODEST_W-1:0] out_old_dest;
	logic [PC_W-1:0]    out_pc;
	logic [COUNT_W-1:0] occupancy;
	logic               is_empty;
	logic               is_full;
	logic [COUNT_W-1:0] free_slots;

	// Planned operations and predicted results
	rob_op_t     pending_ops[$];
	rob_status_t rob_expect_q[$];

	// Predictor state
	entry_t rob_mem[ROB_DEPTH];
	int     rob_head;
	int     rob_tail;
	int     rob_cnt;

	// Planning shadow: pointers and which slots hold data
	int                 plan_head;
	int                 plan_tail;
	int                 plan_cnt;
	logic [ROB_DEPTH-1:0] plan_written;
	int                 plan_total;

	int   cyc;
	logic op_taken;
	logic calm;
	int   err_cnt;
	int   n_ops_done;
	int   n_results;
	int   n_rejects;
	int   n_flushes;
	int   n_full_seen;
	int   hold_left;
	logic hold_done;

	active_list_ring_deque #(
		.DEPTH(ROB_DEPTH)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.mode              (mode),
		.slot_offset       (slot_offset),
		.entry_done        (entry_done),
		.entry_exception   (entry_exception),
		.entry_logical_dest(entry_logical_dest),
		.entry_old_dest    (entry_old_dest),
		.entry_pc          (entry_pc),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.ok                (ok),
		.out_done          (out_done),
		.out_exception     (out_exception),
		.out_logical_dest  (out_logical_dest),
		.out_old_dest      (out_old_dest),
		.out_pc            (out_pc),
		.occupancy         (occupancy),
		.is_empty          (is_empty),
		.is_full           (is_full),
		.free_slots        (free_slots)
	);

	always #5 clk = ~clk;

	// No idling on either side inside this window
	assign calm = (cyc >= 700) && (cyc < 1000);

	// Apply one operation to the predicted deque and return its result
	function automatic rob_status_t rob_apply(rob_op_t op);
		rob_status_t r;
		r = '0;
		r.ok = 1'b1;
		case (op.mode)
			OP_PUSH: begin
				if (rob_cnt >= ROB_DEPTH) begin
					r.ok = 1'b0;
				end else begin
					rob_mem[rob_tail] = op.ent;
					rob_tail = (rob_tail + 1) % ROB_DEPTH;
					rob_cnt++;
				end
			end
			OP_POP_FRONT: begin
				if (rob_cnt == 0) begin
					r.ok = 1'b0;
				end else begin
					rob_head = (rob_head + 1) % ROB_DEPTH;
					rob_cnt--;
				end
			end
			OP_POP_BACK: begin
				if (rob_cnt == 0) begin
					r.ok = 1'b0;
				end else begin
					rob_tail = (rob_tail + ROB_DEPTH - 1) % ROB_DEPTH;
					rob_cnt--;
				end
			end
			OP_RD_FRONT: begin
				if (rob_cnt == 0)
					r.ok = 1'b0;
				else
					r.ent = rob_mem[rob_head];
			end
			OP_RD_BACK: begin
				if (rob_cnt == 0)
					r.ok = 1'b0;
				else
					r.ent = rob_mem[(rob_tail + ROB_DEPTH - 1) % ROB_DEPTH];
			end
			OP_RD_AT: r.ent = rob_mem[(rob_head + int'(op.idx)) % ROB_DEPTH];
			OP_WR_AT: rob_mem[(rob_head + int'(op.idx)) % ROB_DEPTH] = op.ent;
			default: begin
				rob_head = 0;
				rob_tail = 0;
				rob_cnt  = 0;
				n_flushes++;
			end
		endcase
		if (!r.ok)
			n_rejects++;
		if (rob_cnt == ROB_DEPTH)
			n_full_seen++;
		r.occ   = COUNT_W'(rob_cnt);
		r.empty = (rob_cnt == 0);
		r.full  = (rob_cnt == ROB_DEPTH);
		r.free  = COUNT_W'(ROB_DEPTH - rob_cnt);
		return r;
	endfunction

	function automatic entry_t rand_entry();
		entry_t e;
		e.done         = 1'($urandom_range(0, 1));
		e.exception    = 1'($urandom_range(0, 1));
		e.logical_dest = LDEST_W'($urandom);
		e.old_dest     = ODEST_W'($urandom);
		e.pc           = {$urandom, $urandom};
		return e;
	endfunction

	// Queue one operation; steer indexed reads away from slots never written
	function automatic void plan_op(mode_t m, logic [INDEX_W-1:0] idx, entry_t e);
		rob_op_t it;
		int      k;
		int      s;
		if (m == OP_RD_AT && !plan_written[(plan_head + int'(idx)) % ROB_DEPTH]) begin
			s = -1;
			for (k = 0; k < ROB_DEPTH; k++)
				if (s < 0 && plan_written[k])
					s = k;
			if (s < 0)
				m = OP_WR_AT;
			else
				idx = INDEX_W'((s - plan_head + ROB_DEPTH) % ROB_DEPTH);
		end
		case (m)
			OP_PUSH: begin
				if (plan_cnt < ROB_DEPTH) begin
					plan_written[plan_tail] = 1'b1;
					plan_tail = (plan_tail + 1) % ROB_DEPTH;
					plan_cnt++;
				end
			end
			OP_POP_FRONT: begin
				if (plan_cnt > 0) begin
					plan_head = (plan_head + 1) % ROB_DEPTH;
					plan_cnt--;
				end
			end
			OP_POP_BACK: begin
				if (plan_cnt > 0) begin
					plan_tail = (plan_tail + ROB_DEPTH - 1) % ROB_DEPTH;
					plan_cnt--;
				end
			end
			OP_WR_AT: plan_written[(plan_head + int'(idx)) % ROB_DEPTH] = 1'b1;
			OP_FLUSH: begin
				plan_head = 0;
				plan_tail = 0;
				plan_cnt  = 0;
			end
			default: ;
		endcase
		it.mode = m;
		it.idx  = idx;
		it.ent  = e;
		pending_ops.insert(pending_ops.size(), it);
		plan_total++;
	endfunction

	function automatic mode_t pick_read();
		case ($urandom_range(0, 2))
			0:       return OP_RD_FRONT;
			1:       return OP_RD_BACK;
			default: return OP_RD_AT;
		endcase
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	// Plan the whole stimulus, run it and report
	initial begin
		int      phase;
		int      reps;
		int      k;
		mode_t   m;
		entry_t  ones;
		entry_t  alt;

		arst_n             = 1'b0;
		in_valid           = 1'b0;
		out_stall          = 1'b0;
		mode               = '0;
		slot_offset        = '0;
		entry_done         = 1'b0;
		entry_exception    = 1'b0;
		entry_logical_dest = '0;
		entry_old_dest     = '0;
		entry_pc           = '0;
		cyc         = 0;
		op_taken    = 1'b0;
		err_cnt     = 0;
		n_ops_done  = 0;
		n_results   = 0;
		n_rejects   = 0;
		n_flushes   = 0;
		n_full_seen = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		rob_head    = 0;
		rob_tail    = 0;
		rob_cnt     = 0;
		plan_head   = 0;
		plan_tail   = 0;
		plan_cnt    = 0;
		plan_written = '0;
		plan_total  = 0;
		ones = '1;
		alt  = entry_t'({1'b1, 1'b0, 5'h0a, 6'h15, 64'h5555_aaaa_5555_aaaa});

		// Directed: empty rejects, extremes, every operation, flush
		plan_op(OP_RD_FRONT, '0, rand_entry());
		plan_op(OP_RD_BACK, '0, rand_entry());
		plan_op(OP_POP_FRONT, '0, rand_entry());
		plan_op(OP_POP_BACK, '0, rand_entry());
		plan_op(OP_PUSH, '0, ones);
		plan_op(OP_PUSH, '0, '0);
		plan_op(OP_RD_FRONT, '0, rand_entry());
		plan_op(OP_RD_BACK, '0, rand_entry());
		plan_op(OP_RD_AT, 5'd0, rand_entry());
		plan_op(OP_RD_AT, 5'd1, rand_entry());
		plan_op(OP_WR_AT, 5'd1, alt);
		plan_op(OP_RD_AT, 5'd1, rand_entry());
		plan_op(OP_POP_BACK, '0, rand_entry());
		plan_op(OP_RD_BACK, '0, rand_entry());
		plan_op(OP_POP_FRONT, '0, rand_entry());
		plan_op(OP_POP_FRONT, '0, rand_entry());
		plan_op(OP_PUSH, '0, ~alt);
		plan_op(OP_PUSH, '0, rand_entry());
		plan_op(OP_FLUSH, '0, rand_entry());
		plan_op(OP_RD_FRONT, '0, rand_entry());
		plan_op(OP_WR_AT, 5'd31, ones);
		plan_op(OP_RD_AT, 5'd31, rand_entry());
		plan_op(OP_RD_AT, 5'd0, rand_entry());

		// Random phases: fill and drain first, then a random mix
		reps = plan_total;
		phase = 0;
		while (plan_total < reps + RAND_OPS) begin
			case ((phase < 2) ? phase : $urandom_range(0, 4))
				0: begin
					// fill, often past full so extra pushes bounce
					k = ($urandom_range(0, 1) || phase == 0) ?
						ROB_DEPTH + $urandom_range(1, 3) : $urandom_range(1, ROB_DEPTH);
					k = k - plan_cnt;
					while (k > 0) begin
						if ($urandom_range(0, 3) != 0) begin
							plan_op(OP_PUSH, INDEX_W'($urandom), rand_entry());
							k--;
						end else begin
							plan_op(pick_read(), INDEX_W'($urandom), rand_entry());
						end
					end
				end
				1: begin
					// drain to empty and a little past it
					k = plan_cnt + $urandom_range(1, 3);
					while (k > 0) begin
						if ($urandom_range(0, 3) != 0) begin
							m = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
							k--;
						end else begin
							m = pick_read();
						end
						plan_op(m, INDEX_W'($urandom), rand_entry());
					end
				end
				2: begin
					for (k = $urandom_range(20, 60); k > 0; k--) begin
						m = ($urandom_range(0, 39) == 0) ? OP_FLUSH :
							mode_t'($urandom_range(0, 6));
						plan_op(m, INDEX_W'($urandom), rand_entry());
					end
				end
				3: begin
					for (k = $urandom_range(8, 24); k > 0; k--) begin
						m = $urandom_range(0, 1) ? OP_RD_AT : OP_WR_AT;
						plan_op(m, INDEX_W'($urandom), rand_entry());
					end
				end
				default: plan_op(OP_FLUSH, INDEX_W'($urandom), rand_entry());
			endcase
			phase++;
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || rob_expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d deque operations, %0d results checked, %0d rejected on full/empty,",
			n_ops_done, n_results, n_rejects);
		$display("  %0d flushes, %0d operations left the list full.", n_flushes, n_full_seen);
		if (err_cnt == 0)
			$display("[active_list_ring_deque] OK");
		else
			$display("[active_list_ring_deque] ERROR");
		$finish;
	end

	// Limit the run
	initial begin
		#2000000;
		$display("[active_list_ring_deque] ERROR");
		$finish;
	end

	// Count cycles; on each input transfer predict its result and retire the op
	always @(posedge clk) begin
		cyc++;
		if (arst_n && in_valid && !in_stall) begin
			rob_expect_q.insert(rob_expect_q.size(), rob_apply(pending_ops[0]));
			pending_ops.delete(0);
			op_taken = 1'b1;
			n_ops_done++;
		end
	end

	// Drive the next op after a transfer or an idle cycle; hold it while stalled
	always @(negedge clk) begin
		logic go;
		go = 1'b0;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || op_taken) begin
			op_taken = 1'b0;
			go = (pending_ops.size() != 0) && (calm || $urandom_range(0, 99) >= 10);
			in_valid <= go;
			if (go) begin
				mode               <= pending_ops[0].mode;
				slot_offset        <= pending_ops[0].idx;
				entry_done         <= pending_ops[0].ent.done;
				entry_exception    <= pending_ops[0].ent.exception;
				entry_logical_dest <= pending_ops[0].ent.logical_dest;
				entry_old_dest     <= pending_ops[0].ent.old_dest;
				entry_pc           <= pending_ops[0].ent.pc;
			end
		end
	end

	// Stall results at random; once, hold off long enough to back up the input
	always @(negedge clk) begin
		logic st;
		st = 1'b0;
		if (arst_n) begin
			if (!hold_done && n_results >= 300) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				st = 1'b1;
				hold_left--;
			end else if (!calm) begin
				st = ($urandom_range(0, 99) < 10);
			end
		end
		out_stall <= st;
	end

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin
		rob_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (rob_expect_q.size() == 0) begin
				$error("result transfer with no operation outstanding");
				err_cnt++;
			end else begin
				want = rob_expect_q[0];
				rob_expect_q.delete(0);
				check_field("ok", 64'(want.ok), 64'(ok));
				check_field("out_done", 64'(want.ent.done), 64'(out_done));
				check_field("out_exception", 64'(want.ent.exception), 64'(out_exception));
				check_field("out_logical_dest", 64'(want.ent.logical_dest),
					64'(out_logical_dest));
				check_field("out_old_dest", 64'(want.ent.old_dest), 64'(out_old_dest));
				check_field("out_pc", want.ent.pc, out_pc);
				check_field("occupancy", 64'(want.occ), 64'(occupancy));
				check_field("is_empty", 64'(want.empty), 64'(is_empty));
				check_field("is_full", 64'(want.full), 64'(is_full));
				check_field("free_slots", 64'(want.free), 64'(free_slots));
			end
		end
	end

endmodule
